// ===== rtl/core/rksa_pkg.sv =====
package rksa_pkg;

	// Sizes fixed by the request and result formats
	localparam int SLOT_COUNT_DEF = 64;
	localparam int KEY_W          = 31;
	localparam int REFS_W         = 16;
	localparam int SLOT_W         = 6;

	localparam logic [REFS_W-1:0] REFS_MAX = '1;

	// Request codes; every other code acts as a lookup
	localparam logic [1:0] REQ_ACQUIRE = 2'd1;
	localparam logic [1:0] REQ_RELEASE = 2'd2;

	// Result status codes
	localparam logic [1:0] STATUS_OK     = 2'd0;
	localparam logic [1:0] STATUS_FULL   = 2'd1;
	localparam logic [1:0] STATUS_ABSENT = 2'd2;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [KEY_W-1:0] owner_key;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [SLOT_W-1:0] slot_index;
		logic [REFS_W-1:0] ref_count;
		logic              slot_freed;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_REFS,
		S_UPDATE,
		S_POP,
		S_ALLOC_POP,
		S_ALLOC_NEW,
		S_FAIL
	} ctl_state_t;

	// What the result register is loaded with, and which table writes go with it
	typedef enum logic [2:0] {
		RES_UPDATE,
		RES_ALLOC_POP,
		RES_ALLOC_NEW,
		RES_FULL,
		RES_ABSENT
	} res_kind_t;

	typedef struct packed {
		logic      cap;
		logic      scan_clr;
		logic      scan_en;
		logic      refs_rd;
		logic      pop_rd;
		logic      res_load;
		res_kind_t res_kind;
	} ctl_cmd_t;

	typedef struct packed {
		logic       scan_done;
		logic       hit;
		logic       stack_empty;
		logic       table_full;
		logic       out_free;
		logic [1:0] req_type;
	} ctl_sts_t;

endpackage

// ===== rtl/core/rksa_datapath.sv =====
module rksa_datapath import rksa_pkg::*; #(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  req_t     req,
	input  ctl_cmd_t cmd,
	output ctl_sts_t sts,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output rsp_t     rsp
);

	localparam int IW = $clog2(SLOT_COUNT);
	localparam int CW = $clog2(SLOT_COUNT + 1);

	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
	} key_ent_t;

	// Slot tables, one write and one read port each
	key_ent_t          key_mem   [SLOT_COUNT];
	logic [REFS_W-1:0] refs_mem  [SLOT_COUNT];
	logic [IW-1:0]     stack_mem [SLOT_COUNT];

	logic [1:0]        req_type_q;
	logic [KEY_W-1:0]  key_q;
	logic [CW-1:0]     scan_cnt_q;
	logic              rd_pend_s1;
	logic [IW-1:0]     rd_idx_s1;
	key_ent_t          key_rd_s1;
	logic              hit_q;
	logic [IW-1:0]     slot_q;
	logic [REFS_W-1:0] refs_rd_q;
	logic [IW-1:0]     stack_rd_q;
	logic [CW-1:0]     free_top_q;
	logic [CW-1:0]     next_unused_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic              match_now;
	logic              scan_issue;
	logic              is_acq;
	logic              is_rel;
	logic [REFS_W-1:0] refs_new;
	logic              refs_freed;
	logic              do_update;
	logic              do_alloc;
	logic [IW-1:0]     alloc_slot;
	logic [CW-1:0]     free_top_dec;
	logic              key_we;
	logic [IW-1:0]     wr_addr;
	key_ent_t          key_wr;
	logic              refs_we;
	logic [REFS_W-1:0] refs_wr;
	logic              push_we;
	logic              out_free;
	rsp_t              rsp_d;

	// Key scan: one entry read per cycle, compared the cycle after
	assign match_now  = rd_pend_s1 && key_rd_s1.valid && (key_rd_s1.key == key_q);
	assign scan_issue = cmd.scan_en && !hit_q && !match_now && (scan_cnt_q != next_unused_q);

	// Count update for a mapped key
	always_comb begin
		is_acq     = (req_type_q == REQ_ACQUIRE);
		is_rel     = (req_type_q == REQ_RELEASE);
		refs_new   = refs_rd_q;
		refs_freed = 1'b0;
		if (is_acq) begin
			if (refs_rd_q != REFS_MAX) begin
				refs_new = refs_rd_q + REFS_W'(1);
			end
		end else if (is_rel && refs_rd_q != '0) begin
			refs_new   = refs_rd_q - REFS_W'(1);
			refs_freed = (refs_rd_q == REFS_W'(1));
		end
	end

	assign do_update    = cmd.res_load && (cmd.res_kind == RES_UPDATE);
	assign do_alloc     = cmd.res_load &&
	                      (cmd.res_kind == RES_ALLOC_POP || cmd.res_kind == RES_ALLOC_NEW);
	assign alloc_slot   = (cmd.res_kind == RES_ALLOC_POP) ? stack_rd_q : next_unused_q[IW-1:0];
	assign free_top_dec = free_top_q - CW'(1);

	// Table write ports
	always_comb begin
		key_we       = do_alloc || (do_update && refs_freed);
		wr_addr      = do_alloc ? alloc_slot : slot_q;
		key_wr.valid = do_alloc;
		key_wr.key   = key_q;
		refs_we      = do_alloc || (do_update && (is_acq || is_rel));
		refs_wr      = do_alloc ? REFS_W'(1) : refs_new;
		push_we      = do_update && refs_freed && (free_top_q != CW'(SLOT_COUNT));
	end

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[wr_addr] <= key_wr;
		end
		if (scan_issue) begin
			key_rd_s1 <= key_mem[scan_cnt_q[IW-1:0]];
			rd_idx_s1 <= scan_cnt_q[IW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (refs_we) begin
			refs_mem[wr_addr] <= refs_wr;
		end
		if (cmd.refs_rd) begin
			refs_rd_q <= refs_mem[slot_q];
		end
	end

	always_ff @(posedge clk) begin
		if (push_we) begin
			stack_mem[free_top_q[IW-1:0]] <= slot_q;
		end
		if (cmd.pop_rd) begin
			stack_rd_q <= stack_mem[free_top_dec[IW-1:0]];
		end
	end

	// Request capture, matched slot and result payload
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			req_type_q <= req.req_type;
			key_q      <= req.owner_key;
		end
		if (match_now) begin
			slot_q <= rd_idx_s1;
		end
		if (cmd.res_load) begin
			rsp_q <= rsp_d;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_cnt_q    <= '0;
			rd_pend_s1    <= 1'b0;
			hit_q         <= 1'b0;
			free_top_q    <= '0;
			next_unused_q <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (cmd.scan_clr) begin
				scan_cnt_q <= '0;
				rd_pend_s1 <= 1'b0;
				hit_q      <= 1'b0;
			end else begin
				rd_pend_s1 <= scan_issue;
				if (scan_issue) begin
					scan_cnt_q <= scan_cnt_q + CW'(1);
				end
				if (match_now) begin
					hit_q <= 1'b1;
				end
			end
			if (cmd.pop_rd) begin
				free_top_q <= free_top_dec;
			end else if (push_we) begin
				free_top_q <= free_top_q + CW'(1);
			end
			if (cmd.res_load && cmd.res_kind == RES_ALLOC_NEW) begin
				next_unused_q <= next_unused_q + CW'(1);
			end
			if (cmd.res_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Result formatting
	always_comb begin
		rsp_d.status     = STATUS_ABSENT;
		rsp_d.slot_index = '0;
		rsp_d.ref_count  = '0;
		rsp_d.slot_freed = 1'b0;
		case (cmd.res_kind)
			RES_UPDATE: begin
				rsp_d.status     = STATUS_OK;
				rsp_d.slot_index = SLOT_W'(slot_q);
				rsp_d.ref_count  = refs_new;
				rsp_d.slot_freed = refs_freed;
			end
			RES_ALLOC_POP, RES_ALLOC_NEW: begin
				rsp_d.status     = STATUS_OK;
				rsp_d.slot_index = SLOT_W'(alloc_slot);
				rsp_d.ref_count  = REFS_W'(1);
			end
			RES_FULL: begin
				rsp_d.status = STATUS_FULL;
			end
			default: begin
				rsp_d.status = STATUS_ABSENT;
			end
		endcase
	end

	assign out_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		sts.scan_done   = hit_q || (!rd_pend_s1 && (scan_cnt_q == next_unused_q));
		sts.hit         = hit_q;
		sts.stack_empty = (free_top_q == '0);
		sts.table_full  = (next_unused_q == CW'(SLOT_COUNT));
		sts.out_free    = out_free;
		sts.req_type    = req_type_q;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== rtl/core/rksa_ctrl.sv =====
module rksa_ctrl import rksa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  ctl_sts_t sts,
	output ctl_cmd_t cmd
);

	ctl_state_t state_q;
	ctl_state_t state_d;
	logic       acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.scan_done) begin
					if (sts.hit) begin
						state_d = S_REFS;
					end else if (sts.req_type == REQ_ACQUIRE) begin
						if (!sts.stack_empty) begin
							state_d = S_POP;
						end else if (!sts.table_full) begin
							state_d = S_ALLOC_NEW;
						end else begin
							state_d = S_FAIL;
						end
					end else begin
						state_d = S_FAIL;
					end
				end
			end
			S_REFS: state_d = S_UPDATE;
			S_POP:  state_d = S_ALLOC_POP;
			S_UPDATE, S_ALLOC_POP, S_ALLOC_NEW, S_FAIL: begin
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign acc = (state_q == S_IDLE) && req_valid;

	// Commands to the datapath
	always_comb begin
		req_stall    = 1'b1;
		cmd.cap      = 1'b0;
		cmd.scan_clr = 1'b0;
		cmd.scan_en  = 1'b0;
		cmd.refs_rd  = 1'b0;
		cmd.pop_rd   = 1'b0;
		cmd.res_load = 1'b0;
		cmd.res_kind = RES_ABSENT;
		case (state_q)
			S_IDLE: begin
				req_stall    = 1'b0;
				cmd.cap      = acc;
				cmd.scan_clr = acc;
			end
			S_SCAN: cmd.scan_en = 1'b1;
			S_REFS: cmd.refs_rd = 1'b1;
			S_POP:  cmd.pop_rd  = 1'b1;
			S_UPDATE: begin
				cmd.res_load = sts.out_free;
				cmd.res_kind = RES_UPDATE;
			end
			S_ALLOC_POP: begin
				cmd.res_load = sts.out_free;
				cmd.res_kind = RES_ALLOC_POP;
			end
			S_ALLOC_NEW: begin
				cmd.res_load = sts.out_free;
				cmd.res_kind = RES_ALLOC_NEW;
			end
			S_FAIL: begin
				cmd.res_load = sts.out_free;
				cmd.res_kind = (sts.req_type == REQ_ACQUIRE) ? RES_FULL : RES_ABSENT;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

endmodule

// ===== rtl/core/refcounted_key_slot_allocator.sv =====
// Reference-counted key slot allocator. Maps 31-bit owner keys onto
// SLOT_COUNT slots with a 16-bit saturating count each. Lookup returns the
// key's slot and count; acquire maps the key if needed (freed slots first,
// most recently freed on top, then slots never used, else status full) and
// counts up; release counts down and, at zero, unmaps the key and returns
// the slot to the free list. One request is worked at a time. The search
// covers the slots handed out since reset (at most SLOT_COUNT) and stops
// at a hit; an acquire that reuses a freed slot adds a read of the free
// stack. Keys sit in a memory that is searched one entry per cycle,
// followed by a count read on a hit and a write-back step. The write-back
// also waits while an earlier result is held by rsp_stall. The result sits
// in an output register, so the next request is taken while a result
// waits on rsp_stall. No initialization pass after reset.
module refcounted_key_slot_allocator import rksa_pkg::*; #(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	rksa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	rksa_datapath #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// ===== rtl/core/rksa_checker.sv =====
module rksa_checker import rksa_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// A stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// Requests are worked one at a time: no transfer right after a transfer
	a_req_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while one is in progress");

	// Failed requests carry no slot, count or free flag
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != STATUS_OK |->
			rsp.slot_index == '0 && rsp.ref_count == '0 && !rsp.slot_freed)
		else $error("failed result carries data");

	// A freed slot reports success with a zero count
	a_freed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.slot_freed |-> rsp.status == STATUS_OK && rsp.ref_count == '0)
		else $error("freed slot with nonzero count");

endmodule

bind refcounted_key_slot_allocator rksa_checker u_rksa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

// ===== bench/testbench.sv =====
import rksa_pkg::*;

// Tracks the key-to-slot table alongside the block and holds the results it should produce
class slot_map_tracker;
	logic [KEY_W-1:0]  key_of  [SLOT_COUNT_DEF];
	bit                mapped  [SLOT_COUNT_DEF];
	logic [REFS_W-1:0] refs    [SLOT_COUNT_DEF];
	logic [SLOT_W-1:0] free_lifo [SLOT_COUNT_DEF];
	int                free_depth;
	int                fresh_next;
	rsp_t              expected_rsp [$];
	int                mismatches;

	function new();
		for (int i = 0; i < SLOT_COUNT_DEF; i++) begin
			key_of[i] = '0;
			mapped[i] = 0;
			refs[i]   = '0;
			free_lifo[i] = '0;
		end
		free_depth = 0;
		fresh_next = 0;
		mismatches = 0;
	endfunction

	function int outstanding();
		return expected_rsp.size();
	endfunction

	// Apply one accepted request to the table and queue the result it gives
	function void note_request(req_t r);
		rsp_t e;
		int   hit;
		int   s;
		e   = '0;
		hit = -1;
		for (int i = 0; i < SLOT_COUNT_DEF; i++)
			if (hit < 0 && mapped[i] && key_of[i] == r.owner_key)
				hit = i;

		if (r.req_type == REQ_ACQUIRE) begin
			s = hit;
			// new mapping: most recently freed slot first, then a never-used one
			if (s < 0 && free_depth > 0) begin
				free_depth--;
				s = free_lifo[free_depth];
			end else if (s < 0 && fresh_next < SLOT_COUNT_DEF) begin
				s = fresh_next;
				fresh_next++;
			end
			if (s < 0) begin
				e.status = STATUS_FULL;
			end else begin
				if (hit < 0) begin
					key_of[s] = r.owner_key;
					mapped[s] = 1;
					refs[s]   = '0;
				end
				if (refs[s] != REFS_MAX)
					refs[s]++;
				e.status     = STATUS_OK;
				e.slot_index = SLOT_W'(s);
				e.ref_count  = refs[s];
			end
		end else if (hit < 0) begin
			e.status = STATUS_ABSENT;
		end else begin
			e.status     = STATUS_OK;
			e.slot_index = SLOT_W'(hit);
			// release drops the count; at zero the slot goes back on the free stack
			if (r.req_type == REQ_RELEASE && refs[hit] != 0) begin
				refs[hit]--;
				if (refs[hit] == 0) begin
					mapped[hit] = 0;
					if (free_depth < SLOT_COUNT_DEF) begin
						free_lifo[free_depth] = SLOT_W'(hit);
						free_depth++;
					end
					e.slot_freed = 1'b1;
				end
			end
			e.ref_count = refs[hit];
		end
		expected_rsp.push_back(e);
	endfunction

	function void compare_field(string name, logic [REFS_W-1:0] e, logic [REFS_W-1:0] a);
		if (e !== a) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
			mismatches++;
		end
	endfunction

	// Compare one accepted result with the oldest expectation
	function void check_response(rsp_t a);
		rsp_t e;
		if (expected_rsp.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual %p", $time, a);
			mismatches++;
			return;
		end
		e = expected_rsp.pop_front();
		compare_field("status", REFS_W'(e.status), REFS_W'(a.status));
		compare_field("slot_index", REFS_W'(e.slot_index), REFS_W'(a.slot_index));
		compare_field("ref_count", e.ref_count, a.ref_count);
		compare_field("slot_freed", REFS_W'(e.slot_freed), REFS_W'(a.slot_freed));
	endfunction
endclass

module testbench;
	localparam logic [1:0] REQ_LOOKUP = 2'd0;
	localparam logic [1:0] REQ_SPARE  = 2'd3;
	localparam int         POOL_SIZE  = 90;
	localparam int         QUIET_LIMIT = 3000;
	localparam int         DRAIN_CYCLES = 80;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	slot_map_tracker   sb;
	bit                idle_off = 0;
	logic [KEY_W-1:0]  key_pool [POOL_SIZE];
	int                quiet_cycles = 0;

	refcounted_key_slot_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	function automatic int pick_gap();
		return idle_off ? 0 : $urandom_range(0, 19);
	endfunction

	// Present one request after an idle gap and hold it until the transfer
	task automatic send_item(req_t r, int gap);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (req_stall);
		sb.note_request(r);
	endtask

	task automatic issue(logic [1:0] t, logic [KEY_W-1:0] k);
		req_t r;
		r.req_type  = t;
		r.owner_key = k;
		send_item(r, pick_gap());
	endtask

	// Stop sending and hold off until every result is back
	task automatic drain();
		req_valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
	endtask

	function automatic req_t random_request(int acq_w, int rel_w);
		req_t r;
		int   roll;
		roll = $urandom_range(0, 99);
		if (roll < acq_w)
			r.req_type = REQ_ACQUIRE;
		else if (roll < acq_w + rel_w)
			r.req_type = REQ_RELEASE;
		else if (roll < 95)
			r.req_type = REQ_LOOKUP;
		else
			r.req_type = REQ_SPARE;
		// mostly keys from the working set, some noise keys
		if ($urandom_range(0, 99) < 8)
			r.owner_key = KEY_W'($urandom);
		else
			r.owner_key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
		return r;
	endfunction

	task automatic run_phase(int count, int acq_w, int rel_w, bit no_gaps);
		idle_off = no_gaps;
		repeat (count) send_item(random_request(acq_w, rel_w), pick_gap());
		drain();
	endtask

	// Result side: random stall before each transfer, then check it
	initial begin
		int n;
		do @(posedge clk); while (!arst_n);
		forever begin
			n = idle_off ? 0 : $urandom_range(0, 19);
			if (n > 0) begin
				rsp_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!rsp_valid);
			sb.check_response(rsp);
		end
	end

	// Watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		sb = new();
		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = KEY_W'($urandom);
		key_pool[0] = '0;
		key_pool[1] = '1;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// empty table: lookup, release and spare code all miss
		issue(REQ_LOOKUP, '0);
		issue(REQ_RELEASE, '0);
		issue(REQ_SPARE, '0);

		// repeated acquires on the all-ones key, back to back
		idle_off = 1;
		repeat (6) issue(REQ_ACQUIRE, '1);
		idle_off = 0;
		issue(REQ_LOOKUP, '1);
		issue(REQ_SPARE, '1);
		issue(REQ_RELEASE, '1);
		issue(REQ_ACQUIRE, '1);
		issue(REQ_ACQUIRE, '1);

		// release to zero, then reuse through the free stack in LIFO order
		issue(REQ_ACQUIRE, '0);
		issue(REQ_ACQUIRE, '0);
		issue(REQ_RELEASE, '0);
		issue(REQ_RELEASE, '0);
		issue(REQ_LOOKUP, '0);
		issue(REQ_RELEASE, '0);
		issue(REQ_ACQUIRE, 31'd5);
		issue(REQ_ACQUIRE, 31'd6);
		issue(REQ_RELEASE, 31'd6);
		issue(REQ_RELEASE, 31'd5);
		issue(REQ_ACQUIRE, 31'd7);
		issue(REQ_ACQUIRE, 31'd8);
		issue(REQ_SPARE, 31'd8);
		drain();

		// fill to full, drain, then mixed traffic
		run_phase(200, 75, 10, 0);
		run_phase(130, 20, 70, 0);
		run_phase(110, 55, 35, 1);
		run_phase(110, 45, 45, 0);
		run_phase(80, 20, 70, 0);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
